/* src/sacd_pkg.sv */
`default_nettype none

package sacd_pkg;

  // Fixed field widths of the access and result channels and of the access stamp.
  localparam int ADDR_W     = 16;
  localparam int SET_W      = 6;
  localparam int WAY_W      = 3;
  localparam int STAMP_W    = 32;

  // Widest set index the directory ever uses.
  localparam int MAX_SET_BITS = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS           = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LRU    = 2'd3;

  // Register reset values.
  localparam logic [3:0] RST_OFFSET_BITS    = 4'd2;
  localparam logic [2:0] RST_SET_INDEX_BITS = 3'd0;
  localparam logic [3:0] RST_WAYS           = 4'd8;
  localparam logic       RST_REPLACE_LRU    = 1'b1;

  // Per-entry status bits, kept apart from tag and stamp so that reset can clear them.
  typedef struct packed {
    logic valid;
    logic dirty;
  } flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } state_e;

endpackage

`default_nettype wire

/* src/set_assoc_cache_directory.sv */
// Tag directory of a set-associative cache with LRU or FIFO replacement.
// The access channel (in_valid_i / in_stall_o) carries a byte address and a
// write flag; each accepted transfer yields exactly one result transfer on
// the result channel (out_valid_o / out_stall_i): hit flag, block number,
// set number and the way that was hit, filled or replaced.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes offset bits,
// set index bits, ways and the LRU/FIFO select; it is always ready and is
// meant to be written while no access is in flight.
// Each access passes the read of its set from the way banks, the compare
// and the write back of one way, which loads the output register.
// A new access is accepted in the write-back cycle, so a held result in the
// output register does not stop the next access from being read; a stalled
// result holds the write back of the following access.
// After reset the valid and dirty bits are cleared by a pass over the bank
// rows, during which no access is accepted; configuration writes are taken
// throughout.

`default_nettype none

module set_assoc_cache_directory #(
  parameter int ADDR_BITS    = 16,
  parameter int TOTAL_BLOCKS = 64,
  parameter int MAX_WAYS     = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sacd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sacd_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_is_write_i,
  input  logic [sacd_pkg::ADDR_W-1:0]     in_address_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            out_hit_o,
  output logic [sacd_pkg::ADDR_W-1:0]     out_memory_block_o,
  output logic [sacd_pkg::SET_W-1:0]      out_set_number_o,
  output logic [sacd_pkg::WAY_W-1:0]      out_way_used_o
);
  import sacd_pkg::*;

  // Address bits that take part; the tag never exceeds them.
  localparam int AMW   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int TAG_W = AMW;
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << AMW) - 64'd1);

  // Largest usable number of ways and the width that holds it.
  localparam int WAY_LIM = (MAX_WAYS < TOTAL_BLOCKS) ? MAX_WAYS : TOTAL_BLOCKS;
  localparam int NW_W    = $clog2(WAY_LIM + 1);

  // The entries are spread over NB banks by their low index bits, so the ways of any
  // set sit in distinct banks and the whole set is read in parallel.
  localparam int LG      = (MAX_WAYS > 2) ? $clog2(MAX_WAYS) : 1;
  localparam int NB      = 1 << LG;
  localparam int ROWS    = (TOTAL_BLOCKS + NB - 1) / NB;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ENT_W   = $clog2(TOTAL_BLOCKS + NB);

  // Geometry check width for ways shifted by the set bits.
  localparam int TB_W    = $clog2(TOTAL_BLOCKS + 1);
  localparam int GEOM_W  = ((NW_W + MAX_SET_BITS) > TB_W) ? (NW_W + MAX_SET_BITS) : TB_W;

  // The oldest-stamp search is split: SPLIT tree levels in the
  // compare cycle, the rest in the write-back cycle.
  localparam int SPLIT   = (LG + 1) / 2;
  localparam int MID     = NB >> SPLIT;

  typedef struct packed {
    logic               en;
    logic [LG-1:0]      idx;
    logic [STAMP_W-1:0] stamp;
  } node_t;

  // Configuration registers.
  logic [3:0] offset_bits_q;
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic       replace_lru_q;

  // Control state.
  state_e             state_q, state_d;
  logic               clearing_q;
  logic [ROW_W-1:0]   clr_row_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               out_valid_q;

  // Access held through compare and write back.
  logic               wr_q;
  logic               lru_q;
  logic [TAG_W-1:0]   tag_q;
  logic [ADDR_W-1:0]  blk_q;
  logic [SET_W-1:0]   set_q;
  logic [NW_W-1:0]    nw_q;
  logic [LG-1:0]      base_lo_q;
  logic [ROW_W-1:0]   row_q[NB];

  // Compare results.
  logic               found_q;
  logic [LG-1:0]      found_way_q;
  logic               found_hit_q;
  logic               found_dirty_q;
  node_t              mid_q[MID];

  // Result register.
  logic               out_hit_q;
  logic [ADDR_W-1:0]  out_blk_q;
  logic [SET_W-1:0]   out_set_q;
  logic [WAY_W-1:0]   out_way_q;

  logic in_fire;
  logic upd_fire;

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= RST_OFFSET_BITS;
      set_bits_q    <= RST_SET_INDEX_BITS;
      ways_q        <= RST_WAYS;
      replace_lru_q <= RST_REPLACE_LRU;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OFFSET_BITS:    offset_bits_q <= cfg_data_i[3:0];
        CFG_SET_INDEX_BITS: set_bits_q    <= cfg_data_i[2:0];
        CFG_WAYS:           ways_q        <= cfg_data_i[3:0];
        CFG_REPLACE_LRU:    replace_lru_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Address split and bank rows for an incoming access.
  // ---------------------------------------------------------------------------
  logic [NW_W-1:0]         nw_d;
  logic [2:0]              set_cap;
  logic [2:0]              sb_d;
  logic [ADDR_W-1:0]       addr_eff;
  logic [ADDR_W-1:0]       blk_d;
  logic [SET_W-1:0]        set_d;
  logic [TAG_W-1:0]        tag_d;
  logic [SET_W+NW_W-1:0]   base_prod;
  logic [ENT_W-1:0]        base_d;
  logic [ROW_W-1:0]        row_d[NB];

  always_comb begin
    // Out-of-range way counts are pulled back into the legal range.
    if (ways_q == 4'd0) begin
      nw_d = NW_W'(1);
    end else if ({1'b0, ways_q} > 5'(WAY_LIM)) begin
      nw_d = NW_W'(WAY_LIM);
    end else begin
      nw_d = NW_W'(ways_q);
    end

    // The number of sets shrinks until all sets fit into the directory.
    set_cap = (set_bits_q > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_q;
    sb_d    = 3'd0;
    for (int k = 0; k <= MAX_SET_BITS; k++) begin
      if ((3'(k) <= set_cap) && ((GEOM_W'(nw_d) << k) <= GEOM_W'(TOTAL_BLOCKS))) begin
        sb_d = 3'(k);
      end
    end

    addr_eff  = in_address_i & ADDR_MASK;
    blk_d     = addr_eff >> offset_bits_q;
    set_d     = SET_W'(blk_d & ((ADDR_W'(1) << sb_d) - ADDR_W'(1)));
    tag_d     = TAG_W'(addr_eff >> (5'(offset_bits_q) + 5'(sb_d)));
    base_prod = set_d * nw_d;
    base_d    = ENT_W'(base_prod);
  end

  // Bank b holds way (b - base) mod NB of the selected set.
  for (genvar b = 0; b < NB; b++) begin : g_rows
    logic [LG-1:0]    k_way;
    logic [ENT_W-1:0] ent;
    assign k_way    = LG'(b) - base_d[LG-1:0];
    assign ent      = base_d + ENT_W'(k_way);
    assign row_d[b] = ROW_W'(ent >> LG);
  end

  // ---------------------------------------------------------------------------
  // Way banks.
  // ---------------------------------------------------------------------------
  flags_t             rd_flags[NB];
  logic [TAG_W-1:0]   rd_tag[NB];
  logic [STAMP_W-1:0] rd_stamp[NB];

  logic [LG-1:0]      way_sel;
  logic [LG-1:0]      bank_sel;
  logic [ROW_W-1:0]   wr_row;
  flags_t             wr_flags;
  logic               data_en;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic hit_bank;
    assign hit_bank = upd_fire && (bank_sel == LG'(b));

    sacd_bank #(
      .ROWS  (ROWS),
      .TAG_W (TAG_W)
    ) u_bank (
      .clk_i         (clk_i),
      .rd_en_i       (in_fire),
      .rd_row_i      (row_d[b]),
      .flag_we_i     (clearing_q || hit_bank),
      .data_we_i     (hit_bank && data_en),
      .wr_row_i      (clearing_q ? clr_row_q : wr_row),
      .flag_wdata_i  (clearing_q ? flags_t'('0) : wr_flags),
      .tag_wdata_i   (tag_q),
      .stamp_wdata_i (stamp_q),
      .rd_flags_o    (rd_flags[b]),
      .rd_tag_o      (rd_tag[b]),
      .rd_stamp_o    (rd_stamp[b])
    );
  end

  // ---------------------------------------------------------------------------
  // Compare cycle: rotate the banks into way order, find the first way that is
  // free or holds the tag, and reduce the stamps part of the way.
  // ---------------------------------------------------------------------------
  logic          found_d;
  logic [LG-1:0] found_way_d;
  logic          found_hit_d;
  logic          found_dirty_d;
  node_t         look_lvl[NB];

  always_comb begin
    logic [LG-1:0] bk;
    logic          cand;
    found_d       = 1'b0;
    found_way_d   = '0;
    found_hit_d   = 1'b0;
    found_dirty_d = 1'b0;
    // Walk downward so that the lowest matching way is the one kept.
    for (int w = NB - 1; w >= 0; w--) begin
      bk   = base_lo_q + LG'(w);
      cand = (w < int'(nw_q)) &&
             (!rd_flags[bk].valid || (rd_tag[bk] == tag_q));
      if (cand) begin
        found_d       = 1'b1;
        found_way_d   = LG'(w);
        found_hit_d   = rd_flags[bk].valid;
        found_dirty_d = rd_flags[bk].dirty;
      end
    end

    for (int w = 0; w < NB; w++) begin
      bk              = base_lo_q + LG'(w);
      look_lvl[w].en    = (w < int'(nw_q));
      look_lvl[w].idx   = LG'(w);
      look_lvl[w].stamp = rd_stamp[bk];
    end
    // The upper node replaces the lower one only on a strictly older stamp or when the lower one lies outside the set.
    for (int l = 0; l < SPLIT; l++) begin
      for (int n = 0; n < (NB >> (l + 1)); n++) begin
        if (look_lvl[2*n+1].en &&
            (!look_lvl[2*n].en || (look_lvl[2*n+1].stamp < look_lvl[2*n].stamp))) begin
          look_lvl[n] = look_lvl[2*n+1];
        end else begin
          look_lvl[n] = look_lvl[2*n];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Write-back cycle: finish the oldest-stamp search and update one way.
  // ---------------------------------------------------------------------------
  node_t upd_lvl[MID];

  always_comb begin
    for (int m = 0; m < MID; m++) begin
      upd_lvl[m] = mid_q[m];
    end
    for (int l = 0; l < LG - SPLIT; l++) begin
      for (int n = 0; n < (MID >> (l + 1)); n++) begin
        if (upd_lvl[2*n+1].en &&
            (!upd_lvl[2*n].en || (upd_lvl[2*n+1].stamp < upd_lvl[2*n].stamp))) begin
          upd_lvl[n] = upd_lvl[2*n+1];
        end else begin
          upd_lvl[n] = upd_lvl[2*n];
        end
      end
    end

    way_sel  = found_q ? found_way_q : upd_lvl[0].idx;
    bank_sel = base_lo_q + way_sel;
    wr_row   = row_q[bank_sel];

    // A hit keeps an existing dirty bit; a fill or replacement takes the write flag.
    wr_flags.valid = 1'b1;
    wr_flags.dirty = wr_q || (found_q && found_hit_q && found_dirty_q);
    // Tag and stamp are rewritten except on a hit under FIFO.
    data_en = !(found_q && found_hit_q) || lru_q;
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign upd_fire   = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || !((state_q == ST_IDLE) || upd_fire);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_d = in_fire ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clearing_q  <= 1'b1;
      clr_row_q   <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Clearing pass over the bank rows after reset.
      if (clearing_q) begin
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          clearing_q <= 1'b0;
        end else begin
          clr_row_q <= clr_row_q + ROW_W'(1);
        end
      end

      // The access stamp stops at its largest value.
      if (upd_fire && (stamp_q != '1)) begin
        stamp_q <= stamp_q + STAMP_W'(1);
      end

      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      wr_q      <= in_is_write_i;
      lru_q     <= replace_lru_q;
      tag_q     <= tag_d;
      blk_q     <= blk_d;
      set_q     <= set_d;
      nw_q      <= nw_d;
      base_lo_q <= base_d[LG-1:0];
      for (int b = 0; b < NB; b++) begin
        row_q[b] <= row_d[b];
      end
    end
    if (state_q == ST_LOOK) begin
      found_q       <= found_d;
      found_way_q   <= found_way_d;
      found_hit_q   <= found_hit_d;
      found_dirty_q <= found_dirty_d;
      for (int m = 0; m < MID; m++) begin
        mid_q[m] <= look_lvl[m];
      end
    end
    if (upd_fire) begin
      out_hit_q <= found_q && found_hit_q;
      out_blk_q <= blk_q;
      out_set_q <= set_q;
      out_way_q <= WAY_W'(way_sel);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_hit_o          = out_hit_q;
  assign out_memory_block_o = out_blk_q;
  assign out_set_number_o   = out_set_q;
  assign out_way_used_o     = out_way_q;

`ifndef NO_ASSERTIONS
  // An accepted access always goes to the compare cycle next.
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_LOOK))
    else $error("accepted access did not enter the compare cycle");

  // A new result only ever comes out of a write back.
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_UPDATE))
    else $error("result appeared without a write back");

  // The chosen way lies inside the set.
  a_way_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |-> (int'(way_sel) < int'(nw_q)))
    else $error("chosen way outside the set");

  // The access stamp advances by one per completed access until it saturates.
  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && (stamp_q != '1)) |=> (stamp_q == ($past(stamp_q) + STAMP_W'(1))))
    else $error("access stamp did not advance");
`endif

endmodule

`default_nettype wire

/* src/sacd_bank.sv */
`default_nettype none

module sacd_bank #(
  parameter int ROWS  = 8,
  parameter int TAG_W = 16,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [ROW_W-1:0]             rd_row_i,
  input  logic                         flag_we_i,
  input  logic                         data_we_i,
  input  logic [ROW_W-1:0]             wr_row_i,
  input  sacd_pkg::flags_t             flag_wdata_i,
  input  logic [TAG_W-1:0]             tag_wdata_i,
  input  logic [sacd_pkg::STAMP_W-1:0] stamp_wdata_i,
  output sacd_pkg::flags_t             rd_flags_o,
  output logic [TAG_W-1:0]             rd_tag_o,
  output logic [sacd_pkg::STAMP_W-1:0] rd_stamp_o
);
  import sacd_pkg::*;

  flags_t               flag_mem [ROWS];
  logic [TAG_W-1:0]     tag_mem  [ROWS];
  logic [STAMP_W-1:0]   stamp_mem[ROWS];

  flags_t               rd_flags_q;
  logic [TAG_W-1:0]     rd_tag_q;
  logic [STAMP_W-1:0]   rd_stamp_q;

  // A read that meets a write to the same row returns the new contents.
  always_ff @(posedge clk_i) begin
    if (flag_we_i) begin
      flag_mem[wr_row_i] <= flag_wdata_i;
    end
    if (rd_en_i) begin
      rd_flags_q <= (flag_we_i && (wr_row_i == rd_row_i)) ? flag_wdata_i : flag_mem[rd_row_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we_i) begin
      tag_mem[wr_row_i]   <= tag_wdata_i;
      stamp_mem[wr_row_i] <= stamp_wdata_i;
    end
    if (rd_en_i) begin
      if (data_we_i && (wr_row_i == rd_row_i)) begin
        rd_tag_q   <= tag_wdata_i;
        rd_stamp_q <= stamp_wdata_i;
      end else begin
        rd_tag_q   <= tag_mem[rd_row_i];
        rd_stamp_q <= stamp_mem[rd_row_i];
      end
    end
  end

  assign rd_flags_o = rd_flags_q;
  assign rd_tag_o   = rd_tag_q;
  assign rd_stamp_o = rd_stamp_q;

endmodule

`default_nettype wire
